@@ design/spq_pkg.sv @@
`timescale 1ns / 1ps
package spq_pkg;

  localparam int CAPACITY  = 64;
  localparam int ELEM_BITS = 32;
  localparam int PRIO_BITS = 16;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_DEQ = 2'd1;
  localparam logic [1:0] OP_QRY = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic exec;
  } cmd_t;

endpackage

@@ design/stable_priority_queue_core.sv @@
`timescale 1ns / 1ps
// channel  | ports                                                | moves
// in       | in_valid, in_ready, in_func, in_elem, in_prio         | one operation word
// out      | out_valid, out_ready, out_front_elem, out_front_prio, | one status word
//          | out_count, out_is_empty, out_error                    |
// Each word is applied in the sorted cell array: all 64 cells compare
// against the new priority in parallel and shift together.
// The result shows the cycle after acceptance; a new word is taken in the same
// cycle the previous result leaves, so one word per cycle when out_ready stays high.
// Synchronous active-low reset empties the queue; cell contents are not cleared.
// A stalled result holds; no input is taken while it waits.
module stable_priority_queue_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [spq_pkg::ELEM_BITS-1:0] in_elem,
  input  logic [spq_pkg::PRIO_BITS-1:0] in_prio,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spq_pkg::ELEM_BITS-1:0] out_front_elem,
  output logic [spq_pkg::PRIO_BITS-1:0] out_front_prio,
  output logic [spq_pkg::CNT_BITS-1:0]  out_count,
  output logic                          out_is_empty,
  output logic [1:0]                    out_error
);
  import spq_pkg::*;

  cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  spq_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_func    (in_func),
    .in_elem    (in_elem),
    .in_prio    (in_prio),
    .front_elem (out_front_elem),
    .front_prio (out_front_prio),
    .count      (out_count),
    .is_empty   (out_is_empty),
    .error      (out_error)
  );

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= CNT_BITS'(CAPACITY)))
    else $error("count beyond capacity");

  a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error == ERR_FULL) |-> (out_count == CNT_BITS'(CAPACITY)))
    else $error("full refusal with free cells");

  a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error == ERR_EMPTY) |-> out_is_empty)
    else $error("empty refusal on nonempty queue");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted word produced no result");

endmodule

@@ design/spq_ctrl.sv @@
`timescale 1ns / 1ps
module spq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output spq_pkg::cmd_t cmd
);
  import spq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.exec  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.exec = in_valid;
        if (in_valid) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        out_valid = 1'b1;
        // take the next word in the same cycle the result leaves
        in_ready  = out_ready;
        cmd.exec  = out_ready && in_valid;
        if (out_ready && !in_valid) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/spq_datapath.sv @@
`timescale 1ns / 1ps
module spq_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  spq_pkg::cmd_t                   cmd,
  input  logic [1:0]                      in_func,
  input  logic [spq_pkg::ELEM_BITS-1:0]   in_elem,
  input  logic [spq_pkg::PRIO_BITS-1:0]   in_prio,
  output logic [spq_pkg::ELEM_BITS-1:0]   front_elem,
  output logic [spq_pkg::PRIO_BITS-1:0]   front_prio,
  output logic [spq_pkg::CNT_BITS-1:0]    count,
  output logic                            is_empty,
  output logic [1:0]                      error
);
  import spq_pkg::*;

  logic [ELEM_BITS-1:0] cell_elem_r [CAPACITY];
  logic [PRIO_BITS-1:0] cell_prio_r [CAPACITY];
  logic [CNT_BITS-1:0]  fill_r;
  logic [CNT_BITS-1:0]  fill_nxt;
  logic [1:0]           err_r;
  logic [1:0]           err_nxt;
  logic [CAPACITY-1:0]  ins;
  logic                 full;
  logic                 empty;
  logic                 do_enq;
  logic                 do_deq;

  assign full   = (fill_r == CNT_BITS'(CAPACITY));
  assign empty  = (fill_r == '0);
  assign do_enq = cmd.exec && (in_func == OP_ENQ) && !full;
  assign do_deq = cmd.exec && (in_func == OP_DEQ) && !empty;

  // ins marks cells from the insert point up to the first free cell
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ins[i] = ((CNT_BITS'(i) < fill_r) && (cell_prio_r[i] > in_prio)) ||
               (CNT_BITS'(i) == fill_r);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ELEM_BITS-1:0] up_elem;
    logic [PRIO_BITS-1:0] up_prio;

    if (g == CAPACITY - 1) begin : g_last
      assign up_elem = cell_elem_r[g];
      assign up_prio = cell_prio_r[g];
    end else begin : g_mid
      assign up_elem = cell_elem_r[g+1];
      assign up_prio = cell_prio_r[g+1];
    end

    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (do_enq && ins[g]) begin
          cell_elem_r[g] <= in_elem;
          cell_prio_r[g] <= in_prio;
        end else if (do_deq) begin
          cell_elem_r[g] <= up_elem;
          cell_prio_r[g] <= up_prio;
        end
      end
    end else begin : g_body
      logic take_new;

      assign take_new = !ins[g-1];
      always_ff @(posedge clk) begin
        if (do_enq && ins[g]) begin
          cell_elem_r[g] <= take_new ? in_elem : cell_elem_r[g-1];
          cell_prio_r[g] <= take_new ? in_prio : cell_prio_r[g-1];
        end else if (do_deq) begin
          cell_elem_r[g] <= up_elem;
          cell_prio_r[g] <= up_prio;
        end
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    err_nxt  = err_r;
    if (cmd.exec) begin
      err_nxt = ERR_NONE;
      if (in_func == OP_ENQ && full) begin
        err_nxt = ERR_FULL;
      end else if (in_func == OP_DEQ && empty) begin
        err_nxt = ERR_EMPTY;
      end
    end
    if (do_enq) begin
      fill_nxt = fill_r + CNT_BITS'(1);
    end else if (do_deq) begin
      fill_nxt = fill_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      err_r  <= ERR_NONE;
    end else begin
      fill_r <= fill_nxt;
      err_r  <= err_nxt;
    end
  end

  assign is_empty   = empty;
  assign front_elem = empty ? '0 : cell_elem_r[0];
  assign front_prio = empty ? '0 : cell_prio_r[0];
  assign count      = fill_r;
  assign error      = err_r;

endmodule

@@ tb/spq_front_checker.sv @@
`timescale 1ns / 1ps
module spq_front_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [spq_pkg::ELEM_BITS-1:0] in_elem,
  input  logic [spq_pkg::PRIO_BITS-1:0] in_prio,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [spq_pkg::ELEM_BITS-1:0] out_front_elem,
  input  logic [spq_pkg::PRIO_BITS-1:0] out_front_prio,
  input  logic [spq_pkg::CNT_BITS-1:0]  out_count,
  input  logic                          out_is_empty,
  input  logic [1:0]                    out_error,
  output int                            mismatches,
  output int                            pending
);
  import spq_pkg::*;

  typedef struct packed {
    logic [ELEM_BITS-1:0] front_elem;
    logic [PRIO_BITS-1:0] front_prio;
    logic [CNT_BITS-1:0]  count;
    logic                 is_empty;
    logic [1:0]           error;
  } status_t;

  logic [ELEM_BITS-1:0] slot_e [CAPACITY];
  logic [PRIO_BITS-1:0] slot_p [CAPACITY];
  int unsigned          depth = 0;
  status_t              expected_status [$];

  // Apply one operation word to the shadow queue and return the status it yields.
  function automatic status_t apply_word(logic [1:0] func, logic [ELEM_BITS-1:0] e,
                                         logic [PRIO_BITS-1:0] p);
    int unsigned pos;
    status_t     s;
    s.error = ERR_NONE;
    if (func == OP_ENQ) begin
      if (depth >= CAPACITY) begin
        s.error = ERR_FULL;
      end else begin
        pos = 0;
        // equal priorities stay in arrival order: stop at the first strictly greater one
        while (pos < depth && slot_p[pos] <= p) pos++;
        for (int unsigned i = depth; i > pos; i--) begin
          slot_e[i] = slot_e[i-1];
          slot_p[i] = slot_p[i-1];
        end
        slot_e[pos] = e;
        slot_p[pos] = p;
        depth++;
      end
    end else if (func == OP_DEQ) begin
      if (depth == 0) begin
        s.error = ERR_EMPTY;
      end else begin
        for (int unsigned i = 1; i < depth; i++) begin
          slot_e[i-1] = slot_e[i];
          slot_p[i-1] = slot_p[i];
        end
        depth--;
      end
    end
    if (depth > 0) begin
      s.front_elem = slot_e[0];
      s.front_prio = slot_p[0];
      s.is_empty   = 1'b0;
    end else begin
      s.front_elem = '0;
      s.front_prio = '0;
      s.is_empty   = 1'b1;
    end
    s.count = CNT_BITS'(depth);
    return s;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Sample at the falling edge: everything is settled for the next rising edge.
  always @(negedge clk) begin : watch
    status_t want;
    if (!rst_n) begin
      depth = 0;
      expected_status.delete();
    end else begin
      if (in_valid && in_ready)
        expected_status.push_back(apply_word(in_func, in_elem, in_prio));
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          $display("%0t: unexpected status word: expected none, got elem %0h prio %0h cnt %0d",
                   $time, out_front_elem, out_front_prio, out_count);
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          check_field("front_elem", 64'(want.front_elem), 64'(out_front_elem));
          check_field("front_prio", 64'(want.front_prio), 64'(out_front_prio));
          check_field("count", 64'(want.count), 64'(out_count));
          check_field("is_empty", 64'(want.is_empty), 64'(out_is_empty));
          check_field("error", 64'(want.error), 64'(out_error));
        end
      end
    end
    pending = expected_status.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import spq_pkg::*;

  localparam logic [1:0] OP_RSVD = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_func;
  logic [ELEM_BITS-1:0] in_elem;
  logic [PRIO_BITS-1:0] in_prio;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  logic [ELEM_BITS-1:0] out_front_elem;
  logic [PRIO_BITS-1:0] out_front_prio;
  logic [CNT_BITS-1:0]  out_count;
  logic                 out_is_empty;
  logic [1:0]           out_error;

  int mismatches;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;

  stable_priority_queue_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_elem       (in_elem),
    .in_prio       (in_prio),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_front_elem(out_front_elem),
    .out_front_prio(out_front_prio),
    .out_count     (out_count),
    .out_is_empty  (out_is_empty),
    .out_error     (out_error)
  );

  spq_front_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_elem       (in_elem),
    .in_prio       (in_prio),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_front_elem(out_front_elem),
    .out_front_prio(out_front_prio),
    .out_count     (out_count),
    .out_is_empty  (out_is_empty),
    .out_error     (out_error),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // Present one word and hold it until the queue takes it.
  task automatic send_word(logic [1:0] f, logic [ELEM_BITS-1:0] e, logic [PRIO_BITS-1:0] p);
    logic took;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_elem  <= e;
    in_prio  <= p;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  function automatic logic [PRIO_BITS-1:0] pick_prio();
    case ($urandom_range(3))
      0, 1:    return PRIO_BITS'($urandom_range(3));
      2:       return PRIO_BITS'($urandom());
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  // Filling runs push toward full, draining runs toward empty.
  task automatic send_random(bit filling);
    int         r;
    logic [1:0] f;
    r = $urandom_range(99);
    if (filling)
      f = (r < 85) ? OP_ENQ : (r < 92) ? OP_DEQ : (r < 96) ? OP_QRY : OP_RSVD;
    else
      f = (r < 5) ? OP_ENQ : (r < 88) ? OP_DEQ : (r < 94) ? OP_QRY : OP_RSVD;
    send_word(f, ELEM_BITS'($urandom()), pick_prio());
  endtask

  initial begin
    int idle_by_phase [4];
    int stall_by_phase [4];
    idle_by_phase  = '{0, 74, 0, 10};
    stall_by_phase = '{0, 0, 74, 10};
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_func  <= OP_QRY;
    in_elem  <= '0;
    in_prio  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue corner cases
    send_word(OP_QRY, '0, '0);
    send_word(OP_DEQ, '1, '1);
    send_word(OP_RSVD, '1, '1);
    // extremes and equal-priority ordering, including a tie at the tail
    send_word(OP_ENQ, '1, '1);
    send_word(OP_ENQ, 32'h0, 16'h0);
    send_word(OP_ENQ, 32'h1, 16'h0);
    send_word(OP_ENQ, 32'h2, 16'hFFFF);
    send_word(OP_ENQ, 32'h3, 16'h8000);
    send_word(OP_ENQ, 32'h4, 16'h8000);
    send_word(OP_ENQ, 32'hA5A5_A5A5, 16'h7FFF);
    send_word(OP_RSVD, 32'h5A5A_5A5A, 16'h1234);
    send_word(OP_QRY, 32'hFFFF_0000, 16'h00FF);
    repeat (7) send_word(OP_DEQ, '0, '0);
    send_word(OP_DEQ, '0, '0);
    send_word(OP_QRY, '0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      for (int seg = 0; seg < 2; seg++)
        for (int k = 0; k < 85; k++) send_random(seg == 0);
    end

    in_valid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
